FILE: design/ddh_pkg.sv
// shared types and constants of the differential-drive heading pid block
// used by every module of the block; depends on nothing
`default_nettype none

package ddh_pkg;

   // heading geometry in 1/16 degree
   localparam int HALF_TURN   = 2880;
   localparam int FULL_TURN   = 5760;
   // bias that makes (diff + half turn) non-negative: half turn plus twelve full turns
   localparam int WRAP_BIAS   = 72000;
   localparam int WRAP_STEPS  = 5;
   localparam int DRIVE_LIMIT = 255;
   localparam int VEL_MIN     = -256;
   localparam int VEL_MAX     = 255;

   // register indexes of the configuration port
   localparam logic [2:0] REG_NAV_ENABLE         = 3'd0;
   localparam logic [2:0] REG_ACCEL_STEP         = 3'd1;
   localparam logic [2:0] REG_DECEL_STEP         = 3'd2;
   localparam logic [2:0] REG_PROP_GAIN          = 3'd3;
   localparam logic [2:0] REG_INTEGRAL_GAIN_DT   = 3'd4;
   localparam logic [2:0] REG_DERIV_GAIN_OVER_DT = 3'd5;
   localparam logic [2:0] REG_INTEGRATE_DEADBAND = 3'd6;
   localparam logic [2:0] REG_TURN_CAP           = 3'd7;

   // reset values of the registers
   localparam logic        RST_NAV_ENABLE         = 1'b1;
   localparam logic [7:0]  RST_ACCEL_STEP         = 8'd2;
   localparam logic [7:0]  RST_DECEL_STEP         = 8'd1;
   localparam logic [15:0] RST_PROP_GAIN          = 16'd768;
   localparam logic [15:0] RST_INTEGRAL_GAIN_DT   = 16'd0;
   localparam logic [15:0] RST_DERIV_GAIN_OVER_DT = 16'd256;
   localparam logic [11:0] RST_INTEGRATE_DEADBAND = 12'd0;
   localparam logic [7:0]  RST_TURN_CAP           = 8'd96;

   typedef struct packed {
      logic        nav_enable;
      logic [7:0]  accel_step;
      logic [7:0]  decel_step;
      logic [15:0] prop_gain;
      logic [15:0] integral_gain_dt;
      logic [15:0] deriv_gain_over_dt;
      logic [11:0] integrate_deadband;
      logic [7:0]  turn_cap;
   } cfg_type;

   // item leaving the state-update stage
   typedef struct packed {
      logic signed [8:0]  vel;
      logic signed [13:0] dif;
      logic signed [12:0] err;
      logic signed [31:0] integ;
   } track_type;

   // load enables of the pid stages
   typedef struct packed {
      logic mul;
      logic sum;
      logic out;
   } pid_load_type;

endpackage

`default_nettype wire

FILE: design/ddh_csr.sv
// configuration register file of the heading pid block
// depends on ddh_pkg for register indexes, reset values and the config struct
`default_nettype none

module ddh_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write,
   input  wire logic [2:0]      csr_index,
   input  wire logic [15:0]     csr_data,
   output ddh_pkg::cfg_type     cfg
);

   ddh_pkg::cfg_type cfg_ff;
   ddh_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ddh_pkg::REG_NAV_ENABLE:         cfg_in.nav_enable         = csr_data[0];
            ddh_pkg::REG_ACCEL_STEP:         cfg_in.accel_step         = csr_data[7:0];
            ddh_pkg::REG_DECEL_STEP:         cfg_in.decel_step         = csr_data[7:0];
            ddh_pkg::REG_PROP_GAIN:          cfg_in.prop_gain          = csr_data;
            ddh_pkg::REG_INTEGRAL_GAIN_DT:   cfg_in.integral_gain_dt   = csr_data;
            ddh_pkg::REG_DERIV_GAIN_OVER_DT: cfg_in.deriv_gain_over_dt = csr_data;
            ddh_pkg::REG_INTEGRATE_DEADBAND: cfg_in.integrate_deadband = csr_data[11:0];
            ddh_pkg::REG_TURN_CAP:           cfg_in.turn_cap           = csr_data[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nav_enable         <= ddh_pkg::RST_NAV_ENABLE;
         cfg_ff.accel_step         <= ddh_pkg::RST_ACCEL_STEP;
         cfg_ff.decel_step         <= ddh_pkg::RST_DECEL_STEP;
         cfg_ff.prop_gain          <= ddh_pkg::RST_PROP_GAIN;
         cfg_ff.integral_gain_dt   <= ddh_pkg::RST_INTEGRAL_GAIN_DT;
         cfg_ff.deriv_gain_over_dt <= ddh_pkg::RST_DERIV_GAIN_OVER_DT;
         cfg_ff.integrate_deadband <= ddh_pkg::RST_INTEGRATE_DEADBAND;
         cfg_ff.turn_cap           <= ddh_pkg::RST_TURN_CAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/ddh_wrap.sv
// heading error wrap to plus or minus half a turn, combinational
// depends on ddh_pkg for the turn constants
`default_nettype none

module ddh_wrap (
   input  wire logic signed [15:0] measured_heading,
   input  wire logic signed [15:0] heading_goal,
   output logic signed [12:0]      err
);

   logic signed [16:0] diff;
   logic signed [18:0] biased;
   logic [17:0]        rem;
   logic signed [13:0] centered;
   logic               diff_pos;

   assign diff     = {heading_goal[15], heading_goal}
                   - {measured_heading[15], measured_heading};
   assign biased   = {{2{diff[16]}}, diff} + 19'(ddh_pkg::WRAP_BIAS);
   assign diff_pos = !diff[16] && (diff != 17'sd0);

   // binary compare-subtract reduction modulo a full turn
   always_comb begin
      rem = biased[17:0];
      for (int i = ddh_pkg::WRAP_STEPS - 1; i >= 0; i--) begin
         if (rem >= 18'(ddh_pkg::FULL_TURN << i)) begin
            rem = rem - 18'(ddh_pkg::FULL_TURN << i);
         end
      end
   end

   assign centered = $signed({1'b0, rem[12:0]}) - 14'(ddh_pkg::HALF_TURN);

   // a positive error landing on the seam stays at plus half a turn
   always_comb begin
      if (rem == 18'd0 && diff_pos) begin
         err = 13'(ddh_pkg::HALF_TURN);
      end else begin
         err = centered[12:0];
      end
   end

endmodule

`default_nettype wire

FILE: design/ddh_track.sv
// state-update stage: velocity ramp, integral with deadband and saturation,
// previous error; depends on ddh_pkg for the config and stage structs and velocity limits
`default_nettype none

module ddh_track (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic signed [12:0]   err,
   input  wire logic signed [8:0]    velocity_goal,
   input  wire ddh_pkg::cfg_type     cfg,
   output ddh_pkg::track_type        track
);

   logic signed [8:0]  vel_ff, vel_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [12:0] prev_ff;
   ddh_pkg::track_type track_ff, track_in;

   logic signed [10:0] vel_x, tv_x, ramp, acc, dec, step;
   logic signed [12:0] mag;
   logic signed [32:0] integ_sum;

   assign vel_x = {{2{vel_ff[8]}}, vel_ff};
   assign tv_x  = {{2{velocity_goal[8]}}, velocity_goal};
   assign acc   = {3'b000, cfg.accel_step};
   assign dec   = {3'b000, cfg.decel_step};
   assign step  = (cfg.accel_step > cfg.decel_step) ? acc : dec;

   always_comb begin
      if (vel_x < tv_x) begin
         ramp = vel_x + acc;
      end else if (vel_x > tv_x) begin
         ramp = vel_x - dec;
      end else begin
         ramp = vel_x;
      end
      // snap to target when within one step
      if (ramp >= tv_x - step && ramp <= tv_x + step) begin
         ramp = tv_x;
      end
      if (ramp < 11'(ddh_pkg::VEL_MIN)) begin
         vel_in = 9'(ddh_pkg::VEL_MIN);
      end else if (ramp > 11'(ddh_pkg::VEL_MAX)) begin
         vel_in = 9'(ddh_pkg::VEL_MAX);
      end else begin
         vel_in = ramp[8:0];
      end
   end

   assign mag       = err[12] ? -err : err;
   assign integ_sum = {integ_ff[31], integ_ff} + {{20{err[12]}}, err};

   always_comb begin
      integ_in = integ_ff;
      if ($unsigned(mag[11:0]) > cfg.integrate_deadband) begin
         if (integ_sum[32] != integ_sum[31]) begin
            integ_in = integ_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
         end else begin
            integ_in = integ_sum[31:0];
         end
      end
   end

   always_comb begin
      track_in.vel   = vel_in;
      track_in.err   = err;
      track_in.dif   = {err[12], err} - {prev_ff[12], prev_ff};
      track_in.integ = integ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff   <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else if (load) begin
         vel_ff   <= vel_in;
         integ_ff <= integ_in;
         prev_ff  <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         track_ff <= track_in;
      end
   end

   assign track = track_ff;

endmodule

`default_nettype wire

FILE: design/ddh_pid.sv
// pid datapath: gain products, sum, shift and turn clamp, drive clamps
// depends on ddh_pkg for the config, stage and load structs and the drive limit
`default_nettype none

module ddh_pid (
   input  wire logic                  clock,
   input  wire ddh_pkg::pid_load_type ld,
   input  wire ddh_pkg::track_type    track,
   input  wire ddh_pkg::cfg_type      cfg,
   output logic signed [8:0]          left_drive,
   output logic signed [8:0]          right_drive,
   output logic signed [8:0]          turn_term,
   output logic signed [8:0]          ramped_velocity
);

   // product stage
   logic signed [29:0] prop_ff;
   logic signed [48:0] integ_ff;
   logic signed [30:0] deriv_ff;
   logic signed [8:0]  vel_mul_ff;
   // sum stage
   logic signed [50:0] sum_ff, sum_in;
   logic signed [8:0]  vel_sum_ff;
   // output stage
   logic signed [8:0]  left_ff, right_ff, turn_ff, vel_out_ff;

   logic signed [38:0] turn_raw, turn_lim;
   logic signed [8:0]  turn_in, left_in, right_in;
   logic signed [9:0]  left_x, right_x;

   always_ff @(posedge clock) begin
      if (ld.mul) begin
         prop_ff    <= $signed({1'b0, cfg.prop_gain}) * track.err;
         integ_ff   <= $signed({1'b0, cfg.integral_gain_dt}) * track.integ;
         deriv_ff   <= $signed({1'b0, cfg.deriv_gain_over_dt}) * track.dif;
         vel_mul_ff <= track.vel;
      end
   end

   assign sum_in = {{21{prop_ff[29]}}, prop_ff}
                 + {{2{integ_ff[48]}}, integ_ff}
                 + {{20{deriv_ff[30]}}, deriv_ff};

   always_ff @(posedge clock) begin
      if (ld.sum) begin
         sum_ff     <= sum_in;
         vel_sum_ff <= vel_mul_ff;
      end
   end

   // floor division by 4096 is the arithmetic shift
   assign turn_raw = sum_ff[50:12];
   assign turn_lim = {31'd0, cfg.turn_cap};

   always_comb begin
      if (turn_raw > turn_lim) begin
         turn_in = turn_lim[8:0];
      end else if (turn_raw < -turn_lim) begin
         turn_in = 9'(-turn_lim);
      end else begin
         turn_in = turn_raw[8:0];
      end
   end

   assign left_x  = {vel_sum_ff[8], vel_sum_ff} - {turn_in[8], turn_in};
   assign right_x = {vel_sum_ff[8], vel_sum_ff} + {turn_in[8], turn_in};

   always_comb begin
      if (left_x > 10'(ddh_pkg::DRIVE_LIMIT)) begin
         left_in = 9'(ddh_pkg::DRIVE_LIMIT);
      end else if (left_x < -10'(ddh_pkg::DRIVE_LIMIT)) begin
         left_in = -9'(ddh_pkg::DRIVE_LIMIT);
      end else begin
         left_in = left_x[8:0];
      end
      if (right_x > 10'(ddh_pkg::DRIVE_LIMIT)) begin
         right_in = 9'(ddh_pkg::DRIVE_LIMIT);
      end else if (right_x < -10'(ddh_pkg::DRIVE_LIMIT)) begin
         right_in = -9'(ddh_pkg::DRIVE_LIMIT);
      end else begin
         right_in = right_x[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld.out) begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         turn_ff    <= turn_in;
         vel_out_ff <= vel_sum_ff;
      end
   end

   assign left_drive      = left_ff;
   assign right_drive     = right_ff;
   assign turn_term       = turn_ff;
   assign ramped_velocity = vel_out_ff;

endmodule

`default_nettype wire

FILE: design/diff_drive_heading_pid_tick.sv
// heading pid tick: six-stage pipeline, one item per cycle while rsp_stall is
// low; a result shows on rsp_valid from the output stage; stages advance on
// their own, so items move up behind a stalled result until every stage is full
// the state loop (velocity, integral, previous error) closes in a single stage
// synchronous reset clears state, valid bits and config registers
`default_nettype none

module diff_drive_heading_pid_tick (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_measured_heading,
   input  wire logic signed [15:0] req_heading_goal,
   input  wire logic signed [8:0]  req_velocity_goal,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [8:0]       rsp_left_drive,
   output logic signed [8:0]       rsp_right_drive,
   output logic signed [8:0]       rsp_turn_term,
   output logic signed [8:0]       rsp_ramped_velocity,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   ddh_pkg::cfg_type      cfg;
   ddh_pkg::track_type    track;
   ddh_pkg::pid_load_type pid_ld;

   // stage valid bits: input, wrap, track, product, sum, output
   logic [5:0] vld_ff, vld_in;
   logic [5:0] rdy;

   logic signed [15:0] meas_ff, tgt_ff;
   logic signed [8:0]  tv0_ff, tv1_ff;
   logic signed [12:0] err1_ff, err_wrap;

   ddh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // a stage takes new data when it is empty or its own item moves on
   always_comb begin
      rdy[5] = !vld_ff[5] || !rsp_stall;
      for (int i = 4; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i + 1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      // disabled ticks are taken and dropped
      if (rdy[0]) begin
         vld_in[0] = req_valid && cfg.nav_enable;
      end
      for (int i = 1; i < 6; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_ff[i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && req_valid) begin
         meas_ff <= req_measured_heading;
         tgt_ff  <= req_heading_goal;
         tv0_ff  <= req_velocity_goal;
      end
   end

   ddh_wrap u_wrap (
      .measured_heading (meas_ff),
      .heading_goal     (tgt_ff),
      .err              (err_wrap)
   );

   always_ff @(posedge clock) begin
      if (rdy[1] && vld_ff[0]) begin
         err1_ff <= err_wrap;
         tv1_ff  <= tv0_ff;
      end
   end

   ddh_track u_track (
      .clock         (clock),
      .reset         (reset),
      .load          (rdy[2] && vld_ff[1]),
      .err           (err1_ff),
      .velocity_goal (tv1_ff),
      .cfg           (cfg),
      .track         (track)
   );

   always_comb begin
      pid_ld.mul = rdy[3] && vld_ff[2];
      pid_ld.sum = rdy[4] && vld_ff[3];
      pid_ld.out = rdy[5] && vld_ff[4];
   end

   ddh_pid u_pid (
      .clock           (clock),
      .ld              (pid_ld),
      .track           (track),
      .cfg             (cfg),
      .left_drive      (rsp_left_drive),
      .right_drive     (rsp_right_drive),
      .turn_term       (rsp_turn_term),
      .ramped_velocity (rsp_ramped_velocity)
   );

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[5];

`ifndef SYNTH
   // turn never exceeds its configured limit
   a_turn_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_term <= $signed({1'b0, cfg.turn_cap}))
                 && (rsp_turn_term >= -$signed({1'b0, cfg.turn_cap})))
      else $error("turn term outside its limit");

   // a tick taken while disabled leaves no item behind
   a_disabled_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !cfg.nav_enable) |=> !vld_ff[0])
      else $error("disabled tick entered the pipeline");

   // a blocked wrap stage keeps its item and data
   a_wrap_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && !rdy[2]) |=> (vld_ff[1] && $stable(err1_ff) && $stable(tv1_ff)))
      else $error("wrap stage lost a blocked item");
`endif

endmodule

`default_nettype wire
